// ===== hdl/rpn_pkg.sv =====
// Package for the RPN stack calculator: command codes, status codes and the
// queue entry type shared by the front end and the execution back end.
// No dependencies.
package rpn_pkg;

   localparam int unsigned StackDepthDefault = 64;
   localparam int unsigned FuncWidth = 3;
   localparam int unsigned NumberWidth = 31;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned StatusWidth = 2;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_PUSH = 3'd0,
      FUNC_ADD  = 3'd1,
      FUNC_SUB  = 3'd2,
      FUNC_MUL  = 3'd3,
      FUNC_DIV  = 3'd4,
      FUNC_GET  = 3'd5,
      FUNC_DUP  = 3'd6,
      FUNC_NOP  = 3'd7
   } func_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK      = 2'd0,
      ST_FEW     = 2'd1,
      ST_DIVZERO = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // One classified command handed from the front end to the back end
   typedef struct packed {
      func_type               func;
      logic [NumberWidth-1:0] number;
   } cmd_type;

endpackage

// ===== hdl/rpn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/rpn_front.sv =====
// Front end: accepts commands, maps them to the command type and keeps a
// two-entry queue toward the back end. Depends on rpn_pkg.
module rpn_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [rpn_pkg::FuncWidth-1:0]      in_func,
   input  logic [rpn_pkg::NumberWidth-1:0]    in_number,
   output logic                               q_valid,
   input  logic                               q_ready,
   output rpn_pkg::cmd_type                   q_cmd
);

   rpn_pkg::cmd_type slot_ff [2];
   rpn_pkg::cmd_type slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = slot_ff[0];

   // Queue next state: shift on pop, write behind the last valid entry
   always_comb begin
      rpn_pkg::cmd_type c;
      c.func   = rpn_pkg::func_type'(in_func);
      c.number = in_number;
      slot_in  = slot_ff;
      cnt_in   = cnt_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_in - 2'd1;
      end
      if (push) begin
         slot_in[cnt_in[0]] = c;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot_ff <= slot_in;
   end

endmodule

// ===== hdl/rpn_back.sv =====
// Back end: executes commands against the operand stack RAM, with a
// bit-serial divider, and holds the result in an output register.
// Depends on rpn_pkg and rpn_ram.
module rpn_back #(
   parameter int unsigned STACK_DEPTH = rpn_pkg::StackDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  rpn_pkg::cmd_type                  q_cmd,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [rpn_pkg::ValueWidth-1:0]    out_value,
   output logic                              out_shown,
   output logic [rpn_pkg::StatusWidth-1:0]   out_status
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned VW = rpn_pkg::ValueWidth;
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
   localparam logic [5:0] LAST_BIT = 6'(VW - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_RD_B, S_RD_A, S_EXEC, S_DIV, S_MUL, S_DONE
   } state_type;

   state_type           state_ff;
   rpn_pkg::cmd_type    cmd_ff;
   logic [CW-1:0]       count_ff;
   logic [VW-1:0]       b_ff, r_ff, rem_ff, quo_ff;
   logic [5:0]          bit_ff;
   logic                neg_ff;
   logic                ov_ff;
   logic [VW-1:0]       val_ff;
   logic                shown_ff;
   rpn_pkg::status_type st_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [VW-1:0]       wr_data, rd_data;

   rpn_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign q_ready    = (state_ff == S_IDLE) && !ov_ff;
   assign out_valid  = ov_ff;
   assign out_value  = val_ff;
   assign out_shown  = shown_ff;
   assign out_status = st_ff;

   // Read address: top of stack first, then the entry below it
   always_comb begin
      rd_addr = AW'(count_ff - CW'(1));
      if (state_ff == S_RD_B) begin
         rd_addr = AW'(count_ff - CW'(2));
      end
   end

   // Remainder step of the restoring divider on magnitudes
   logic [VW:0]   trial;
   logic [VW-1:0] ub;
   assign ub    = b_ff[VW-1] ? (VW'(0) - b_ff) : b_ff;
   assign trial = {rem_ff, quo_ff[VW-1]} - {1'b0, ub};

   // Stack writes: push, duplicate and arithmetic write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(count_ff);
      wr_data = {1'b0, cmd_ff.number};
      if (state_ff == S_EXEC && cmd_ff.func == rpn_pkg::FUNC_PUSH && count_ff != FULL) begin
         wr_en = 1'b1;
      end else if (state_ff == S_RD_A && cmd_ff.func == rpn_pkg::FUNC_DUP) begin
         wr_en   = 1'b1;
         wr_data = rd_data;
      end else if (state_ff == S_DONE && !ov_ff) begin
         wr_en   = 1'b1;
         wr_addr = AW'(count_ff - CW'(1));
         wr_data = r_ff;
      end
   end

   // Sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         if (ov_ff && out_ready) begin
            ov_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid && !ov_ff) begin
                  cmd_ff   <= q_cmd;
                  val_ff   <= '0;
                  shown_ff <= 1'b0;
                  st_ff    <= rpn_pkg::ST_OK;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_IDLE;
               ov_ff    <= 1'b1;
               case (cmd_ff.func)
                  rpn_pkg::FUNC_PUSH: begin
                     if (count_ff == FULL) st_ff <= rpn_pkg::ST_FULL;
                     else count_ff <= count_ff + CW'(1);
                  end
                  rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_SUB,
                  rpn_pkg::FUNC_MUL, rpn_pkg::FUNC_DIV: begin
                     if (count_ff < CW'(2)) st_ff <= rpn_pkg::ST_FEW;
                     else begin
                        ov_ff    <= 1'b0;
                        state_ff <= S_RD_B;
                     end
                  end
                  rpn_pkg::FUNC_GET, rpn_pkg::FUNC_DUP: begin
                     if (count_ff == '0) st_ff <= rpn_pkg::ST_FEW;
                     else if (cmd_ff.func == rpn_pkg::FUNC_DUP && count_ff == FULL)
                        st_ff <= rpn_pkg::ST_FULL;
                     else begin
                        ov_ff    <= 1'b0;
                        state_ff <= S_RD_A;
                     end
                  end
                  default: ;
               endcase
            end
            S_RD_A: begin
               // rd_data holds the top entry
               state_ff <= S_IDLE;
               ov_ff    <= 1'b1;
               if (cmd_ff.func == rpn_pkg::FUNC_DUP) begin
                  count_ff <= count_ff + CW'(1);
               end else begin
                  count_ff <= count_ff - CW'(1);
                  val_ff   <= rd_data;
                  shown_ff <= 1'b1;
               end
            end
            S_RD_B: begin
               // rd_data holds the top entry (b); next read gives a
               b_ff     <= rd_data;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (cmd_ff.func == rpn_pkg::FUNC_DIV) begin
                  if (b_ff == '0) begin
                     st_ff    <= rpn_pkg::ST_DIVZERO;
                     ov_ff    <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     neg_ff   <= rd_data[VW-1] ^ b_ff[VW-1];
                     quo_ff   <= rd_data[VW-1] ? (VW'(0) - rd_data) : rd_data;
                     rem_ff   <= '0;
                     bit_ff   <= '0;
                     state_ff <= S_DIV;
                  end
               end else begin
                  case (cmd_ff.func)
                     rpn_pkg::FUNC_ADD: r_ff <= rd_data + b_ff;
                     rpn_pkg::FUNC_SUB: r_ff <= rd_data - b_ff;
                     default:           r_ff <= VW'(rd_data * b_ff);
                  endcase
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_DONE;
               end
            end
            S_DIV: begin
               // One quotient bit per cycle
               if (!trial[VW]) begin
                  rem_ff <= trial[VW-1:0];
                  quo_ff <= {quo_ff[VW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[VW-2:0], quo_ff[VW-1]};
                  quo_ff <= {quo_ff[VW-2:0], 1'b0};
               end
               bit_ff <= bit_ff + 6'd1;
               if (bit_ff == LAST_BIT) begin
                  if (!trial[VW]) r_ff <= neg_ff ? (VW'(0) - {quo_ff[VW-2:0], 1'b1})
                                                 : {quo_ff[VW-2:0], 1'b1};
                  else r_ff <= neg_ff ? (VW'(0) - {quo_ff[VW-2:0], 1'b0})
                                      : {quo_ff[VW-2:0], 1'b0};
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // Write-back of r happens here (count already decremented)
               val_ff   <= r_ff;
               shown_ff <= 1'b1;
               ov_ff    <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/rpn_stack_calculator_core.sv =====
// Top level of the RPN stack calculator: front-end queue plus execution back end.
// Depends on rpn_pkg, rpn_front, rpn_back.
//
// Each command yields one response. The back end works on one command at a time:
// push, the unused code and errors found at decode (too few operands, stack full)
// are answered from decode; get and duplicate first read the top entry; add,
// subtract, multiply and divide read both operands and write back the result.
// Divide by zero is found after both reads, and divide runs the bit-serial
// restoring divider that produces one quotient bit per cycle. A stalled
// response holds the back end for as long as it waits.
// The operand stack is a RAM with registered read, so operands are fetched one
// per cycle. A two-entry queue lets commands be taken while the back end works.
// The stack RAM needs no clearing after reset; only the entry count is reset.
module rpn_stack_calculator_core #(
   parameter int unsigned STACK_DEPTH = rpn_pkg::StackDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] func, [33:3] number, [39:34] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] value, [32] shown, [34:33] status
);

   logic             q_valid, q_ready;
   rpn_pkg::cmd_type q_cmd;
   logic [31:0]      value;
   logic             shown;
   logic [1:0]       status;

   rpn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_func  (req_tdata[2:0]),
      .in_number(req_tdata[33:3]),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd)
   );

   rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_cmd     (q_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (value),
      .out_shown (shown),
      .out_status(status)
   );

   assign rsp_tdata = {5'd0, status, shown, value};

endmodule

// ===== hdl/rpn_checker.sv =====
// Port-level checker for the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg.
module rpn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // A stalled request keeps its data
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request changed while stalled");

   // A stalled response keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Errors never show a value
   a_err_hidden: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:33] != rpn_pkg::ST_OK |-> !rsp_tdata[32]
         && rsp_tdata[31:0] == '0)
      else $error("error response carries a value");

   // Padding bits are zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:35] == '0)
      else $error("response padding not zero");

   // No response right out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for rpn_stack_calculator_core: drives command
// transactions, predicts each response from a behavioral stack, checks fields.
// Depends on rpn_pkg and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Depth = rpn_pkg::StackDepthDefault;
   localparam int unsigned CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   typedef struct packed {
      logic [31:0]         value;
      logic                shown;
      rpn_pkg::status_type status;
   } answer_type;

   // behavioral stack
   logic [31:0] calc_stack [Depth];
   int unsigned calc_depth = 0;
   answer_type  answer_queue [$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  idle_enable = 1'b1;
   int  hold_cycles = 0;

   rpn_stack_calculator_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // signed divide truncating toward zero, 32-bit wrap
   function automatic logic [31:0] divide_trunc(logic [31:0] a, logic [31:0] b);
      logic [31:0] ua, ub, q;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q = ua / ub;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // update the stack for one command and return its response
   function automatic answer_type calc_command(rpn_pkg::func_type fn, logic [30:0] num);
      answer_type ans;
      logic [31:0] a, b, r;
      ans = '{value: '0, shown: 1'b0, status: rpn_pkg::ST_OK};
      case (fn)
         rpn_pkg::FUNC_PUSH: begin
            if (calc_depth >= Depth) ans.status = rpn_pkg::ST_FULL;
            else begin
               calc_stack[calc_depth] = {1'b0, num};
               calc_depth++;
            end
         end
         rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_SUB, rpn_pkg::FUNC_MUL, rpn_pkg::FUNC_DIV: begin
            if (calc_depth < 2) ans.status = rpn_pkg::ST_FEW;
            else begin
               a = calc_stack[calc_depth-2];
               b = calc_stack[calc_depth-1];
               if (fn == rpn_pkg::FUNC_DIV && b == 0) ans.status = rpn_pkg::ST_DIVZERO;
               else begin
                  case (fn)
                     rpn_pkg::FUNC_ADD: r = a + b;
                     rpn_pkg::FUNC_SUB: r = a - b;
                     rpn_pkg::FUNC_MUL: r = a * b;
                     default:           r = divide_trunc(a, b);
                  endcase
                  calc_depth--;
                  calc_stack[calc_depth-1] = r;
                  ans.value = r;
                  ans.shown = 1'b1;
               end
            end
         end
         rpn_pkg::FUNC_GET: begin
            if (calc_depth == 0) ans.status = rpn_pkg::ST_FEW;
            else begin
               calc_depth--;
               ans.value = calc_stack[calc_depth];
               ans.shown = 1'b1;
            end
         end
         rpn_pkg::FUNC_DUP: begin
            if (calc_depth == 0) ans.status = rpn_pkg::ST_FEW;
            else if (calc_depth >= Depth) ans.status = rpn_pkg::ST_FULL;
            else begin
               calc_stack[calc_depth] = calc_stack[calc_depth-1];
               calc_depth++;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // send one command transaction, with an optional random gap first
   task automatic send_command(rpn_pkg::func_type fn, logic [30:0] num);
      if (idle_enable && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 7)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {6'd0, num, fn};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answer_queue.push_back(calc_command(fn, num));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic logic [30:0] rand_number();
      case ($urandom_range(0, 4))
         0: return 31'd0;
         1: return 31'h7fffffff;
         2: return 31'($urandom_range(0, 9));
         default: return 31'($urandom);
      endcase
   endfunction

   // receiver ready: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= $urandom_range(0, 6);
      end else rsp_tready <= 1'b1;
   end

   // response checker
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value  = rsp_tdata[31:0];
         got.shown  = rsp_tdata[32];
         got.status = rpn_pkg::status_type'(rsp_tdata[34:33]);
         if (answer_queue.size() == 0) begin
            $error("unexpected response transaction %h", rsp_tdata);
            error_count++;
         end else begin
            want = answer_queue.pop_front();
            if (got.value !== want.value) begin
               $error("value expected %h actual %h", want.value, got.value);
               error_count++;
            end
            if (got.shown !== want.shown) begin
               $error("shown expected %b actual %b", want.shown, got.shown);
               error_count++;
            end
            if (got.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic drain_stack();
      while (calc_depth > 0) send_command(rpn_pkg::FUNC_GET, '0);
   endtask

   // errors on empty and single-entry stack, unused code, extremes
   task automatic test_corner_cases();
      send_command(rpn_pkg::FUNC_GET, '0);
      send_command(rpn_pkg::FUNC_DUP, '0);
      send_command(rpn_pkg::FUNC_ADD, '0);
      send_command(rpn_pkg::FUNC_NOP, 31'h7fffffff);
      send_command(rpn_pkg::FUNC_PUSH, 31'h7fffffff);
      send_command(rpn_pkg::FUNC_DIV, '0);
      send_command(rpn_pkg::FUNC_DUP, 31'h5555_5555);
      send_command(rpn_pkg::FUNC_ADD, '0);
      send_command(rpn_pkg::FUNC_PUSH, 31'd0);
      send_command(rpn_pkg::FUNC_DIV, '0);
      send_command(rpn_pkg::FUNC_SUB, '0);
      send_command(rpn_pkg::FUNC_GET, '0);
      send_command(rpn_pkg::FUNC_PUSH, 31'd3);
      send_command(rpn_pkg::FUNC_PUSH, 31'd7);
      send_command(rpn_pkg::FUNC_MUL, '0);
      send_command(rpn_pkg::FUNC_GET, '0);
   endtask

   // most negative divided by most positive (truncates to -1), then -1 by -1 and 1 by 7
   task automatic test_divide_signs();
      send_command(rpn_pkg::FUNC_PUSH, 31'd0);
      send_command(rpn_pkg::FUNC_PUSH, 31'd1);
      send_command(rpn_pkg::FUNC_SUB, '0);          // -1
      send_command(rpn_pkg::FUNC_PUSH, 31'h40000000);
      send_command(rpn_pkg::FUNC_DUP, '0);
      send_command(rpn_pkg::FUNC_ADD, '0);          // most negative
      send_command(rpn_pkg::FUNC_DUP, '0);
      send_command(rpn_pkg::FUNC_PUSH, 31'd1);
      send_command(rpn_pkg::FUNC_SUB, '0);          // 0x7fffffff... keeps signs mixed
      send_command(rpn_pkg::FUNC_DIV, '0);
      send_command(rpn_pkg::FUNC_DIV, '0);
      send_command(rpn_pkg::FUNC_PUSH, 31'd7);
      send_command(rpn_pkg::FUNC_DIV, '0);
      drain_stack();
   endtask

   // fill to full, overflow on push and duplicate, then drain
   task automatic test_full_stack();
      repeat (Depth) send_command(rpn_pkg::FUNC_PUSH, rand_number());
      send_command(rpn_pkg::FUNC_PUSH, 31'd1);
      send_command(rpn_pkg::FUNC_DUP, '0);
      drain_stack();
   endtask

   // long receiver hold-off while commands keep coming
   task automatic test_backpressure();
      @(posedge clock);
      hold_cycles = 200;
      @(negedge clock);
      repeat (12) send_command(rpn_pkg::FUNC_PUSH, rand_number());
      drain_stack();
   endtask

   // random mix, biased toward keeping a few operands on the stack
   task automatic test_random_mix(int count);
      int pick;
      rpn_pkg::func_type fn;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) fn = rpn_pkg::FUNC_NOP;
         else if (pick < 30 || calc_depth < 2 && pick < 60) fn = rpn_pkg::FUNC_PUSH;
         else if (pick < 42) fn = rpn_pkg::FUNC_ADD;
         else if (pick < 52) fn = rpn_pkg::FUNC_SUB;
         else if (pick < 62) fn = rpn_pkg::FUNC_MUL;
         else if (pick < 72) fn = rpn_pkg::FUNC_DIV;
         else if (pick < 86) fn = rpn_pkg::FUNC_GET;
         else fn = rpn_pkg::FUNC_DUP;
         send_command(fn, rand_number());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_corner_cases();
      test_divide_signs();
      test_full_stack();
      test_backpressure();
      test_random_mix(250);
      test_full_stack();
      idle_enable = 1'b0;
      test_random_mix(150);
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
